// ===== sv/ntc_pkg.sv =====
// Shared types, widths and constants for the NTC converter to Celsius pipeline.
// Used by every module of the block; depends on nothing.
package ntc_pkg;

  localparam int ADC_BITS = 12;
  localparam int SAMPLE_W = 12;
  localparam int BETA_W   = 16;
  localparam int R0_W     = 24;
  localparam int TEMP_W   = 11;

  localparam logic [ADC_BITS-1:0] FS = ADC_BITS'((1 << ADC_BITS) - 1);

  localparam int E_W    = 5;
  localparam int M_W    = 32;
  localparam int SQ_N   = 32;
  localparam int LN_W   = 37;
  localparam int L_W    = 39;
  localparam int MAG_W  = 38;
  localparam int INV_W  = 40;
  localparam int DVR_W  = 39;
  localparam int TQ_W   = 49;
  localparam int X_W    = 58;
  localparam int Y_W    = 17;
  localparam int PR_W   = 34;
  localparam int Q0_W   = 11;
  localparam int RR_W   = 18;

  localparam logic [M_W-1:0]   LN2_Q32  = 32'd2977044471;
  localparam logic [INV_W-1:0] INV25    = INV_W'((64'd20 << 32) / 64'd5963);
  localparam logic [X_W-1:0]   K_OFS    = X_W'(64'd27315 << 16);
  localparam logic [X_W-1:0]   SAT_LIM  = X_W'(64'd1024 * 64'd6553600);
  localparam logic [PR_W-1:0]  RECIP100 = PR_W'(41943);
  localparam logic [X_W-1:0]   SCALE100 = X_W'(100);
  localparam logic [RR_W-1:0]  DIV100   = RR_W'(100);
  localparam logic [R0_W-1:0]  FIXED_R  = R0_W'(1000);

  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -11'sd273;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 11'sd1023;

  localparam logic [BETA_W-1:0] BETA_RST = 16'd3614;
  localparam logic [R0_W-1:0]   R0_RST   = 24'd10000;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  // back pipeline stage positions
  localparam int LN_LAT = 35;
  localparam int D1_N   = MAG_W;
  localparam int D2_N   = TQ_W;
  localparam int IDX_A  = LN_LAT;
  localparam int IDX_B  = IDX_A + 1;
  localparam int IDX_D1 = IDX_B + 1;
  localparam int IDX_C  = IDX_D1 + D1_N;
  localparam int IDX_D2 = IDX_C + 1;
  localparam int IDX_P1 = IDX_D2 + D2_N;
  localparam int NST    = IDX_P1 + 3;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    KIND_NORM = 2'd0,
    KIND_LOW  = 2'd1,
    KIND_HIGH = 2'd2
  } kind_e;

  typedef struct packed {
    logic [ADC_BITS-1:0] a;
    logic [ADC_BITS-1:0] b;
    kind_e               kind;
  } item_t;

endpackage

// ===== sv/ntc_ln_lane.sv =====
// Pipelined natural logarithm in Q32 by repeated squaring of the mantissa.
// Uses widths and constants from ntc_pkg.
module ntc_ln_lane (
  input  logic                      clk_i,
  input  logic                      adv_i,
  input  logic [ntc_pkg::R0_W-1:0]  x_i,
  output logic [ntc_pkg::LN_W-1:0]  ln_o
);

  logic [ntc_pkg::E_W-1:0] e_d;
  logic [ntc_pkg::M_W-1:0] m_d;
  logic [ntc_pkg::M_W-1:0] m_q [0:ntc_pkg::SQ_N];
  logic [ntc_pkg::E_W-1:0] e_q [0:ntc_pkg::SQ_N];
  logic [ntc_pkg::M_W-1:0] f_q [0:ntc_pkg::SQ_N];
  logic [2*ntc_pkg::M_W-1:0] sq_d [1:ntc_pkg::SQ_N];
  logic [ntc_pkg::M_W:0]     sh_d [1:ntc_pkg::SQ_N];
  logic [2*ntc_pkg::M_W-1:0] fp_q;
  logic [ntc_pkg::LN_W-1:0]  ep_q;
  logic [ntc_pkg::LN_W-1:0]  ln_q;

  always_comb begin
    e_d = '0;
    for (int i = 1; i < ntc_pkg::R0_W; i++) begin
      if (x_i[i]) begin
        e_d = ntc_pkg::E_W'(i);
      end
    end
    m_d = ntc_pkg::M_W'(x_i) << (ntc_pkg::E_W'(ntc_pkg::M_W - 1) - e_d);
  end

  always_comb begin
    for (int k = 1; k <= ntc_pkg::SQ_N; k++) begin
      sq_d[k] = (2*ntc_pkg::M_W)'(m_q[k-1]) * (2*ntc_pkg::M_W)'(m_q[k-1]);
      sh_d[k] = sq_d[k][2*ntc_pkg::M_W-1:ntc_pkg::M_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m_q[0] <= m_d;
      e_q[0] <= e_d;
      f_q[0] <= '0;
      for (int k = 1; k <= ntc_pkg::SQ_N; k++) begin
        m_q[k] <= sh_d[k][ntc_pkg::M_W] ? sh_d[k][ntc_pkg::M_W:1]
                                        : sh_d[k][ntc_pkg::M_W-1:0];
        f_q[k] <= {f_q[k-1][ntc_pkg::M_W-2:0], sh_d[k][ntc_pkg::M_W]};
        e_q[k] <= e_q[k-1];
      end
      fp_q <= (2*ntc_pkg::M_W)'(f_q[ntc_pkg::SQ_N]) * (2*ntc_pkg::M_W)'(ntc_pkg::LN2_Q32);
      ep_q <= ntc_pkg::LN_W'(e_q[ntc_pkg::SQ_N]) * ntc_pkg::LN_W'(ntc_pkg::LN2_Q32);
      ln_q <= ep_q + ntc_pkg::LN_W'(fp_q[2*ntc_pkg::M_W-1:ntc_pkg::M_W]);
    end
  end

  assign ln_o = ln_q;

endmodule

// ===== sv/ntc_front.sv =====
// Input stage: takes samples, flags the fixed fault cases, pushes to the queue.
// Uses ntc_pkg types.
module ntc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ntc_pkg::SAMPLE_W-1:0] adc_sample_i,
  input  logic [ntc_pkg::BETA_W-1:0]  beta_i,
  input  logic [ntc_pkg::R0_W-1:0]    r0_i,
  input  logic                        full_i,
  output logic                        push_o,
  output ntc_pkg::item_t              item_o
);

  logic                f_valid_q;
  ntc_pkg::item_t      item_q;
  ntc_pkg::item_t      item_d;
  logic                accept;
  logic [ntc_pkg::ADC_BITS-1:0] a;

  assign push_o     = f_valid_q && !full_i;
  assign in_stall_o = f_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    a           = adc_sample_i[ntc_pkg::ADC_BITS-1:0];
    item_d.a    = a;
    item_d.b    = ntc_pkg::FS - a;
    item_d.kind = ntc_pkg::KIND_NORM;
    if (a == '0 || a == ntc_pkg::FS || beta_i == '0 || r0_i == '0) begin
      item_d.kind = ntc_pkg::KIND_LOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (accept) begin
      f_valid_q <= 1'b1;
    end else if (push_o) begin
      f_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// ===== sv/ntc_fifo.sv =====
// Short request queue between the front stage and the conversion pipeline.
// Uses ntc_pkg types and depth.
module ntc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ntc_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           avail_o,
  output ntc_pkg::item_t item_o
);

  ntc_pkg::item_t             mem_q [0:ntc_pkg::FIFO_DEPTH-1];
  logic [ntc_pkg::PTR_W-1:0]  wr_q;
  logic [ntc_pkg::PTR_W-1:0]  rd_q;
  logic [ntc_pkg::CNT_W-1:0]  cnt_q;
  logic                       do_push;
  logic                       do_pop;

  assign full_o  = cnt_q == ntc_pkg::CNT_W'(ntc_pkg::FIFO_DEPTH);
  assign avail_o = cnt_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== sv/ntc_back.sv =====
// Conversion pipeline: logarithms, divide by beta, reciprocal, Celsius scaling.
// Uses ntc_pkg and ntc_ln_lane.
module ntc_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              avail_i,
  input  ntc_pkg::item_t                    head_i,
  output logic                              pop_o,
  input  logic [ntc_pkg::BETA_W-1:0]        beta_i,
  input  logic [ntc_pkg::R0_W-1:0]          r0_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ntc_pkg::TEMP_W-1:0] temp_o,
  output logic                              fault_o
);

  localparam int NST = ntc_pkg::NST;

  logic adv;
  logic v_q [0:NST-1];
  ntc_pkg::kind_e kd_q [0:NST-1];
  ntc_pkg::kind_e kd_c_d;
  logic out_valid_q;
  logic signed [ntc_pkg::TEMP_W-1:0] temp_q;
  logic signed [ntc_pkg::TEMP_W-1:0] temp_d;
  logic fault_q;
  logic fault_d;

  logic [ntc_pkg::LN_W-1:0] ln0, ln1, ln2, ln3;
  logic [ntc_pkg::L_W-1:0]  l_q;
  logic                     neg_b_q;
  logic [ntc_pkg::MAG_W-1:0] mag_b_q;

  logic [ntc_pkg::BETA_W-1:0] r1_q [0:ntc_pkg::D1_N-1];
  logic [ntc_pkg::BETA_W-1:0] r1_d [0:ntc_pkg::D1_N-1];
  logic [ntc_pkg::MAG_W-1:0]  q1_q [0:ntc_pkg::D1_N-1];
  logic [ntc_pkg::MAG_W-1:0]  q1_d [0:ntc_pkg::D1_N-1];
  logic [ntc_pkg::MAG_W-1:0]  n1_q [0:ntc_pkg::D1_N-1];
  logic [ntc_pkg::MAG_W-1:0]  n1_d [0:ntc_pkg::D1_N-1];
  logic                       s1_q [0:ntc_pkg::D1_N-1];

  logic [ntc_pkg::INV_W-1:0] qv;
  logic [ntc_pkg::INV_W-1:0] inv_d;
  logic [ntc_pkg::INV_W-1:0] inv_q;

  logic [ntc_pkg::DVR_W-1:0] r2_q [0:ntc_pkg::D2_N-1];
  logic [ntc_pkg::DVR_W-1:0] r2_d [0:ntc_pkg::D2_N-1];
  logic [ntc_pkg::TQ_W-1:0]  q2_q [0:ntc_pkg::D2_N-1];
  logic [ntc_pkg::TQ_W-1:0]  q2_d [0:ntc_pkg::D2_N-1];
  logic [ntc_pkg::DVR_W-1:0] d2_q [0:ntc_pkg::D2_N-1];
  logic [ntc_pkg::DVR_W-1:0] d2_d [0:ntc_pkg::D2_N-1];

  logic [ntc_pkg::X_W-1:0]  x_q;
  logic [ntc_pkg::X_W-1:0]  xm;
  logic                     hi_q, neg_q, hi3_q, neg3_q;
  logic [ntc_pkg::Y_W-1:0]  y_q, y3_q;
  logic [ntc_pkg::PR_W-1:0] pr_q;
  logic [ntc_pkg::Q0_W-1:0] q0;
  logic [ntc_pkg::Q0_W-1:0] c;
  logic [ntc_pkg::RR_W-1:0] rr;

  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && avail_i;

  ntc_ln_lane u_ln_fix (.clk_i(clk_i), .adv_i(adv), .x_i(ntc_pkg::FIXED_R), .ln_o(ln0));
  ntc_ln_lane u_ln_a   (.clk_i(clk_i), .adv_i(adv),
                        .x_i(ntc_pkg::R0_W'(head_i.a)), .ln_o(ln1));
  ntc_ln_lane u_ln_b   (.clk_i(clk_i), .adv_i(adv),
                        .x_i(ntc_pkg::R0_W'(head_i.b)), .ln_o(ln2));
  ntc_ln_lane u_ln_r0  (.clk_i(clk_i), .adv_i(adv), .x_i(r0_i), .ln_o(ln3));

  always_comb begin
    logic [ntc_pkg::BETA_W:0]  t1;
    logic [ntc_pkg::BETA_W-1:0] r_in1;
    logic [ntc_pkg::MAG_W-1:0]  n_in1, q_in1;
    logic                      ge1;
    for (int j = 0; j < ntc_pkg::D1_N; j++) begin
      r_in1 = (j == 0) ? '0 : r1_q[(j == 0) ? 0 : j-1];
      n_in1 = (j == 0) ? mag_b_q : n1_q[(j == 0) ? 0 : j-1];
      q_in1 = (j == 0) ? '0 : q1_q[(j == 0) ? 0 : j-1];
      t1    = {r_in1, n_in1[ntc_pkg::MAG_W-1]};
      ge1   = t1 >= {1'b0, beta_i};
      r1_d[j] = ge1 ? ntc_pkg::BETA_W'(t1 - {1'b0, beta_i}) : t1[ntc_pkg::BETA_W-1:0];
      n1_d[j] = n_in1 << 1;
      q1_d[j] = {q_in1[ntc_pkg::MAG_W-2:0], ge1};
    end
  end

  always_comb begin
    qv    = ntc_pkg::INV_W'(q1_q[ntc_pkg::D1_N-1]);
    inv_d = s1_q[ntc_pkg::D1_N-1] ? ntc_pkg::INV25 - qv : ntc_pkg::INV25 + qv;
    kd_c_d = kd_q[ntc_pkg::IDX_C-1];
    if (kd_q[ntc_pkg::IDX_C-1] == ntc_pkg::KIND_NORM) begin
      if (inv_d == '0) begin
        kd_c_d = ntc_pkg::KIND_HIGH;
      end else if (inv_d[ntc_pkg::INV_W-1]) begin
        kd_c_d = ntc_pkg::KIND_LOW;
      end
    end
  end

  always_comb begin
    logic [ntc_pkg::DVR_W:0]   t2;
    logic [ntc_pkg::DVR_W-1:0] r_in2, d_in2;
    logic [ntc_pkg::TQ_W-1:0]  q_in2;
    logic                      ge2;
    for (int k = 0; k < ntc_pkg::D2_N; k++) begin
      r_in2 = (k == 0) ? '0 : r2_q[(k == 0) ? 0 : k-1];
      d_in2 = (k == 0) ? inv_q[ntc_pkg::DVR_W-1:0] : d2_q[(k == 0) ? 0 : k-1];
      q_in2 = (k == 0) ? '0 : q2_q[(k == 0) ? 0 : k-1];
      t2    = {r_in2, (k == 0)};
      ge2   = t2 >= {1'b0, d_in2};
      r2_d[k] = ge2 ? ntc_pkg::DVR_W'(t2 - {1'b0, d_in2}) : t2[ntc_pkg::DVR_W-1:0];
      d2_d[k] = d_in2;
      q2_d[k] = {q_in2[ntc_pkg::TQ_W-2:0], ge2};
    end
  end

  assign xm = x_q[ntc_pkg::X_W-1] ? -x_q : x_q;

  always_comb begin
    q0     = pr_q[32:22];
    rr     = ntc_pkg::RR_W'(y3_q) - ntc_pkg::RR_W'(q0) * ntc_pkg::DIV100;
    c      = (rr >= ntc_pkg::DIV100) ? q0 + 1'b1 : q0;
    temp_d = neg3_q ? -$signed(c) : $signed(c);
    fault_d = 1'b0;
    case (kd_q[NST-1])
      ntc_pkg::KIND_LOW: begin
        temp_d  = ntc_pkg::TEMP_MIN;
        fault_d = 1'b1;
      end
      ntc_pkg::KIND_HIGH: begin
        temp_d  = ntc_pkg::TEMP_MAX;
        fault_d = 1'b1;
      end
      default: begin
        if (hi3_q) begin
          temp_d  = ntc_pkg::TEMP_MAX;
          fault_d = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) begin
        v_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q[0] <= avail_i;
      for (int i = 1; i < NST; i++) begin
        v_q[i] <= v_q[i-1];
      end
      out_valid_q <= v_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kd_q[0] <= head_i.kind;
      for (int i = 1; i < NST; i++) begin
        kd_q[i] <= (i == ntc_pkg::IDX_C) ? kd_c_d : kd_q[i-1];
      end
      l_q <= ntc_pkg::L_W'(ln0) + ntc_pkg::L_W'(ln1) - ntc_pkg::L_W'(ln2)
           - ntc_pkg::L_W'(ln3);
      neg_b_q <= l_q[ntc_pkg::L_W-1];
      mag_b_q <= ntc_pkg::MAG_W'(l_q[ntc_pkg::L_W-1] ? -l_q : l_q);
      for (int j = 0; j < ntc_pkg::D1_N; j++) begin
        r1_q[j] <= r1_d[j];
        n1_q[j] <= n1_d[j];
        q1_q[j] <= q1_d[j];
        s1_q[j] <= (j == 0) ? neg_b_q : s1_q[(j == 0) ? 0 : j-1];
      end
      inv_q <= inv_d;
      for (int k = 0; k < ntc_pkg::D2_N; k++) begin
        r2_q[k] <= r2_d[k];
        d2_q[k] <= d2_d[k];
        q2_q[k] <= q2_d[k];
      end
      x_q <= ntc_pkg::X_W'(q2_q[ntc_pkg::D2_N-1]) * ntc_pkg::SCALE100 - ntc_pkg::K_OFS;
      neg_q <= x_q[ntc_pkg::X_W-1];
      hi_q  <= !x_q[ntc_pkg::X_W-1] && (x_q >= ntc_pkg::SAT_LIM);
      y_q   <= xm[32:16];
      pr_q  <= ntc_pkg::PR_W'(y_q) * ntc_pkg::RECIP100;
      y3_q  <= y_q;
      neg3_q <= neg_q;
      hi3_q  <= hi_q;
      temp_q  <= temp_d;
      fault_q <= fault_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign temp_o      = temp_q;
  assign fault_o     = fault_q;

endmodule

// ===== sv/ntc_adc_to_celsius.sv =====
// NTC divider sample to whole degrees Celsius (beta equation), with APB registers.
// One sample per cycle sustained while the output is not stalled.
// The pipeline depth comes from the 32 squaring stages of the log lanes and the two
// bit-per-stage dividers (38 and 49 stages); an output stall freezes the whole pipeline.
// Reset empties the pipeline and loads beta 3614 and nominal resistance 10000.
// Depends on ntc_pkg, ntc_front, ntc_fifo, ntc_back.
module ntc_adc_to_celsius (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ntc_pkg::SAMPLE_W-1:0]       adc_sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [ntc_pkg::TEMP_W-1:0]  temp_celsius_o,
  output logic                               fault_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ntc_pkg::APB_AW-1:0]         paddr,
  input  logic [ntc_pkg::APB_DW-1:0]         pwdata,
  output logic [ntc_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  logic [ntc_pkg::BETA_W-1:0] beta_q;
  logic [ntc_pkg::R0_W-1:0]   r0_q;
  logic                       wr_en;
  logic                       push;
  logic                       full;
  logic                       avail;
  logic                       pop;
  ntc_pkg::item_t             front_item;
  ntc_pkg::item_t             head_item;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? ntc_pkg::APB_DW'(r0_q) : ntc_pkg::APB_DW'(beta_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= ntc_pkg::BETA_RST;
      r0_q   <= ntc_pkg::R0_RST;
    end else if (wr_en) begin
      if (paddr[2]) begin
        r0_q <= pwdata[ntc_pkg::R0_W-1:0];
      end else begin
        beta_q <= pwdata[ntc_pkg::BETA_W-1:0];
      end
    end
  end

  ntc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .adc_sample_i(adc_sample_i),
    .beta_i      (beta_q),
    .r0_i        (r0_q),
    .full_i      (full),
    .push_o      (push),
    .item_o      (front_item)
  );

  ntc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .full_o (full),
    .pop_i  (pop),
    .avail_o(avail),
    .item_o (head_item)
  );

  ntc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (avail),
    .head_i     (head_item),
    .pop_o      (pop),
    .beta_i     (beta_q),
    .r0_i       (r0_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .temp_o     (temp_celsius_o),
    .fault_o    (fault_o)
  );

endmodule

// ===== sv/ntc_checker.sv =====
// Port-level checks for ntc_adc_to_celsius, attached with bind.
// Uses ntc_pkg constants.
module ntc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [ntc_pkg::TEMP_W-1:0] temp_celsius_o,
  input logic                              fault_o,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [ntc_pkg::APB_AW-1:0]        paddr,
  input logic [ntc_pkg::APB_DW-1:0]        pwdata,
  input logic [ntc_pkg::APB_DW-1:0]        prdata,
  input logic                              pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(temp_celsius_o) && $stable(fault_o))
    else $error("stalled result changed");

  a_fault_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o |->
      temp_celsius_o == ntc_pkg::TEMP_MAX || temp_celsius_o == ntc_pkg::TEMP_MIN)
    else $error("fault result not at a limit");

  a_beta_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[2]) ##1 !paddr[2] |->
      prdata == {16'b0, $past(pwdata[15:0])})
    else $error("beta readback mismatch");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind ntc_adc_to_celsius ntc_checker u_ntc_checker (.*);
